// ----- hw/rtl/mtxs_pkg.sv -----
// Package for the transmit frame bit serializer: codes, phase type, ring
// command/status structs and the interleaver block length table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtxs_pkg;

   // parameter defaults
   localparam int STORE_BITS_DEF  = 16384;
   localparam int FLUSH_ZEROS_DEF = 176;

   // longest interleaver block (2400L)
   localparam int BLOCK_MAX = 480 * 24;

   localparam logic [31:0] EOM_WORD = 32'h4B65_A5B2;

   // request codes
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_END   = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DISABLED = 3'd1;
   localparam logic [2:0] ST_OVERFLOW = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_SEQUENCE = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_TX_MODE   = 2'd0;
   localparam logic [1:0] CSR_LSB_FIRST = 2'd1;
   localparam logic [1:0] CSR_SEND_EOM  = 2'd2;
   localparam logic [1:0] CSR_TX_ENABLE = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_OPEN,
      PH_LOAD,
      PH_DRAIN
   } phase_type;

   // commands into the bit ring: load on every accepted item, at most one of clear, push, pop
   typedef struct packed {
      logic load;   // item accepted: capture read row for the result stage
      logic clear;  // start of frame
      logic push;   // store one octet
      logic pop;    // consume one bit
   } ring_cmd_type;

   typedef struct packed {
      logic empty;
      logic last;     // exactly one bit left
      logic no_room;  // another octet would not fit
   } ring_stat_type;

   // interleaver block length in bits per mode
   function automatic logic [13:0] block_len(input logic [3:0] mode);
      logic [13:0] len;
      case (mode)
         4'd0:    len = 14'(15 * 3);
         4'd1:    len = 14'(15 * 24);
         4'd2:    len = 14'(30 * 3);
         4'd3:    len = 14'(30 * 24);
         4'd4:    len = 14'(60 * 3);
         4'd5:    len = 14'(60 * 24);
         4'd6:    len = 14'(120 * 3);
         4'd7:    len = 14'(120 * 24);
         4'd8:    len = 14'(120 * 3);
         4'd9:    len = 14'(240 * 3);
         4'd10:   len = 14'(240 * 24);
         4'd11:   len = 14'(240 * 3);
         4'd12:   len = 14'(480 * 3);
         4'd13:   len = 14'(480 * 24);
         4'd14:   len = 14'(480 * 3);
         4'd15:   len = 14'(960 * 3);
         default: len = 14'(15 * 3);
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mtxs_bit_ring.sv -----
// Payload bit ring: one octet per memory row, bit-granular read pointer.
// Depends on mtxs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtxs_bit_ring #(
   parameter int STORE_BITS = mtxs_pkg::STORE_BITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  mtxs_pkg::ring_cmd_type cmd,
   input  wire  [7:0]            octet,      // bit 0 goes out first
   output mtxs_pkg::ring_stat_type stat,
   output logic                  pop_bit     // bit captured on the last load
);
   import mtxs_pkg::*;

   localparam int ROWS  = (STORE_BITS + 7) / 8;
   localparam int ROW_W = $clog2(ROWS);
   localparam int CNT_W = $clog2(STORE_BITS + 1);

   logic [7:0]       store_mem [ROWS];
   logic [7:0]       rd_row_ff;
   logic [2:0]       rd_off_ff;

   logic [ROW_W-1:0] wr_row_ff, wr_row_in;
   logic [ROW_W-1:0] rd_row_ptr_ff, rd_row_ptr_in;
   logic [2:0]       rd_bit_ff, rd_bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   function automatic logic [ROW_W-1:0] row_next(input logic [ROW_W-1:0] r);
      return (r == ROW_W'(ROWS - 1)) ? '0 : r + ROW_W'(1);
   endfunction

   always_comb begin
      wr_row_in     = wr_row_ff;
      rd_row_ptr_in = rd_row_ptr_ff;
      rd_bit_in     = rd_bit_ff;
      cnt_in        = cnt_ff;
      if (cmd.clear) begin
         wr_row_in     = '0;
         rd_row_ptr_in = '0;
         rd_bit_in     = '0;
         cnt_in        = '0;
      end else if (cmd.push) begin
         wr_row_in = row_next(wr_row_ff);
         cnt_in    = cnt_ff + CNT_W'(8);
      end else if (cmd.pop) begin
         rd_bit_in = rd_bit_ff + 3'd1;
         if (rd_bit_ff == 3'd7) begin
            rd_row_ptr_in = row_next(rd_row_ptr_ff);
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_row_ff     <= '0;
         rd_row_ptr_ff <= '0;
         rd_bit_ff     <= '0;
         cnt_ff        <= '0;
      end else begin
         wr_row_ff     <= wr_row_in;
         rd_row_ptr_ff <= rd_row_ptr_in;
         rd_bit_ff     <= rd_bit_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         store_mem[wr_row_ff] <= octet;
      end
   end

   // registered read; holds while the result stage is held
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_row_ff <= store_mem[rd_row_ptr_ff];
         rd_off_ff <= rd_bit_ff;
      end
   end

   assign pop_bit      = rd_row_ff[rd_off_ff];
   assign stat.empty   = (cnt_ff == '0);
   assign stat.last    = (cnt_ff == CNT_W'(1));
   assign stat.no_room = (cnt_ff > CNT_W'(STORE_BITS - 8));

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STORE_BITS))
      else $error("bit ring count above capacity");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.empty && !cmd.push && !cmd.clear)
      else $error("pop from empty ring or with another command");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> cnt_ff <= CNT_W'(STORE_BITS))
      else $error("push overran the ring");

endmodule

`default_nettype wire

// ----- hw/rtl/modem_tx_frame_bit_serializer.sv -----
// Transmit frame bit serializer for a serial-tone HF modem, top level.
// Depends on mtxs_pkg and mtxs_bit_ring.
//
// Usage:
//   req channel (req_valid / req_stall): one item per request; req_type is
//   start frame, write octet, end frame or read next bit. req_octet_value
//   matters for writes only.
//   rsp channel (rsp_valid / rsp_stall): exactly one item per request, in
//   order: bit, bit-valid flag, last-bit-of-frame flag and a status code.
//   csr port: csr_wr_en / csr_index / csr_wdata, write only, taken in the
//   cycle it is presented; change registers only while no item is in flight.
// Pipeline: a taken request passes through the result stage, then the output register.
// Throughput: one request per cycle while req_stall is low. Each request reads one row of the
//   octet-wide payload memory and a write request also writes one row; the
//   read row is captured at acceptance and the bit picked out in the result stage.
// Reset: synchronous; clears pointers, counters, the frame phase and both
//   pipeline stages, and loads register defaults (mode 5, MSB first,
//   end-of-message word on, transmit disabled). The payload memory is not
//   cleared; only rows written in the current frame are ever read.
// Stall: with the output register held, one more request is taken into the
//   result stage; after that req_stall follows rsp_stall.
`timescale 1ns / 1ps
`default_nettype none

module modem_tx_frame_bit_serializer #(
   parameter int STORE_BITS  = mtxs_pkg::STORE_BITS_DEF,
   parameter int FLUSH_ZEROS = mtxs_pkg::FLUSH_ZEROS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   // request channel
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [1:0] req_type,
   input  wire  [7:0] req_octet_value,
   // result channel
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_bit_out,
   output logic       rsp_bit_valid,
   output logic       rsp_frame_done,
   output logic [2:0] rsp_status,
   // configuration
   input  wire        csr_wr_en,
   input  wire  [1:0] csr_index,
   input  wire  [3:0] csr_wdata
);
   import mtxs_pkg::*;

   // tail zero counter covers flush zeros plus the longest block
   localparam int ZERO_W = $clog2(FLUSH_ZEROS + BLOCK_MAX + 1);

   // configuration registers
   logic [3:0] tx_mode_ff;
   logic       lsb_first_ff;
   logic       send_eom_ff;
   logic       tx_enable_ff;

   // frame state
   phase_type          phase_ff, phase_in;
   logic [5:0]         eom_left_ff, eom_left_in;
   logic [ZERO_W-1:0]  zero_left_ff, zero_left_in;

   // result stage (memory read data lives in the ring)
   logic       p1_valid_ff, p1_valid_in;
   logic       p1_from_ring_ff, p1_from_ring_in;
   logic       p1_tail_bit_ff, p1_tail_bit_in;
   logic       p1_bit_valid_ff, p1_bit_valid_in;
   logic       p1_done_ff, p1_done_in;
   logic [2:0] p1_status_ff, p1_status_in;

   // output register
   logic       out_valid_ff;
   logic       out_bit_ff;
   logic       out_bit_valid_ff;
   logic       out_done_ff;
   logic [2:0] out_status_ff;

   ring_cmd_type  ring_cmd;
   ring_stat_type ring_stat;
   logic          ring_bit;
   logic [7:0]    octet_ser;
   logic          accept;
   logic          p1_move;
   logic          rsp_take;

   // ------------------------------------------------------------------
   // handshake
   // ------------------------------------------------------------------
   assign req_stall = p1_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign p1_move   = p1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign rsp_take  = out_valid_ff && !rsp_stall;

   // first bit out sits in bit 0 of the stored row
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         octet_ser[k] = lsb_first_ff ? req_octet_value[k] : req_octet_value[7 - k];
      end
   end

   // ------------------------------------------------------------------
   // request decode: frame state and result fields
   // ------------------------------------------------------------------
   always_comb begin
      phase_in        = phase_ff;
      eom_left_in     = eom_left_ff;
      zero_left_in    = zero_left_ff;
      ring_cmd        = '0;
      ring_cmd.load   = accept;
      p1_from_ring_in = 1'b0;
      p1_tail_bit_in  = 1'b0;
      p1_bit_valid_in = 1'b0;
      p1_done_in      = 1'b0;
      p1_status_in    = ST_OK;

      if (accept) begin
         if (req_type != REQ_READ && !tx_enable_ff) begin
            p1_status_in = ST_DISABLED;
         end else begin
            case (req_type)
               REQ_START: begin
                  ring_cmd.clear = 1'b1;
                  eom_left_in    = '0;
                  zero_left_in   = '0;
                  phase_in       = PH_OPEN;
               end
               REQ_WRITE: begin
                  if (phase_ff != PH_OPEN && phase_ff != PH_LOAD) begin
                     p1_status_in = ST_SEQUENCE;
                  end else if (ring_stat.no_room) begin
                     p1_status_in = ST_OVERFLOW;
                  end else begin
                     ring_cmd.push = 1'b1;
                     phase_in      = PH_LOAD;
                  end
               end
               REQ_END: begin
                  if (phase_ff == PH_OPEN) begin
                     // empty frame: no tail
                     phase_in = PH_IDLE;
                  end else if (phase_ff != PH_LOAD) begin
                     p1_status_in = ST_SEQUENCE;
                  end else begin
                     eom_left_in  = send_eom_ff ? 6'd32 : 6'd0;
                     zero_left_in = ZERO_W'(FLUSH_ZEROS) + ZERO_W'(block_len(tx_mode_ff));
                     phase_in     = PH_DRAIN;
                  end
               end
               REQ_READ: begin
                  p1_bit_valid_in = 1'b1;
                  if (!ring_stat.empty) begin
                     ring_cmd.pop    = 1'b1;
                     p1_from_ring_in = 1'b1;
                     p1_done_in      = (phase_ff == PH_DRAIN) && ring_stat.last &&
                                       (eom_left_ff == '0) && (zero_left_ff == '0);
                  end else if (phase_ff == PH_DRAIN && eom_left_ff != '0) begin
                     p1_tail_bit_in = EOM_WORD[5'(eom_left_ff - 6'd1)];
                     eom_left_in    = eom_left_ff - 6'd1;
                     p1_done_in     = (eom_left_ff == 6'd1) && (zero_left_ff == '0);
                  end else if (phase_ff == PH_DRAIN && zero_left_ff != '0) begin
                     zero_left_in = zero_left_ff - ZERO_W'(1);
                     p1_done_in   = (zero_left_ff == ZERO_W'(1));
                  end else begin
                     p1_bit_valid_in = 1'b0;
                     p1_status_in    = ST_EMPTY;
                  end
                  if (p1_done_in) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  p1_status_in = ST_SEQUENCE;
               end
            endcase
         end
      end
   end

   assign p1_valid_in = accept ? 1'b1 : (p1_move ? 1'b0 : p1_valid_ff);

   mtxs_bit_ring #(
      .STORE_BITS(STORE_BITS)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ring_cmd),
      .octet  (octet_ser),
      .stat   (ring_stat),
      .pop_bit(ring_bit)
   );

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_mode_ff   <= 4'd5;
         lsb_first_ff <= 1'b0;
         send_eom_ff  <= 1'b1;
         tx_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TX_MODE:   tx_mode_ff   <= csr_wdata;
            CSR_LSB_FIRST: lsb_first_ff <= csr_wdata[0];
            CSR_SEND_EOM:  send_eom_ff  <= csr_wdata[0];
            CSR_TX_ENABLE: tx_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         eom_left_ff  <= '0;
         zero_left_ff <= '0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         eom_left_ff  <= eom_left_in;
         zero_left_ff <= zero_left_in;
         p1_valid_ff  <= p1_valid_in;
         if (p1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_from_ring_ff <= p1_from_ring_in;
         p1_tail_bit_ff  <= p1_tail_bit_in;
         p1_bit_valid_ff <= p1_bit_valid_in;
         p1_done_ff      <= p1_done_in;
         p1_status_ff    <= p1_status_in;
      end
      if (p1_move) begin
         out_bit_ff       <= p1_from_ring_ff ? ring_bit : p1_tail_bit_ff;
         out_bit_valid_ff <= p1_bit_valid_ff;
         out_done_ff      <= p1_done_ff;
         out_status_ff    <= p1_status_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_bit_out    = out_bit_ff;
   assign rsp_bit_valid  = out_bit_valid_ff;
   assign rsp_frame_done = out_done_ff;
   assign rsp_status     = out_status_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_eom_in_drain: assert property (@(posedge clock) disable iff (reset)
      (eom_left_ff != '0 || zero_left_ff != '0) |-> phase_ff == PH_DRAIN)
      else $error("tail counters armed outside drain phase");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && p1_done_in) |=> phase_ff == PH_IDLE)
      else $error("frame end did not return to idle");

   a_done_is_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (rsp_bit_valid && rsp_status == ST_OK))
      else $error("frame end flagged without a valid bit");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      (p1_valid_ff && out_valid_ff && rsp_stall) |=> p1_valid_ff)
      else $error("result stage dropped an item under stall");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for modem_tx_frame_bit_serializer.
// Depends on mtxs_pkg and the RTL. Every result is checked against an in-bench model
// of the frame state, the bit ring and the tail counters.
`timescale 1ns / 1ps

module testbench;
   import mtxs_pkg::*;

   localparam int RING_BITS   = STORE_BITS_DEF;
   localparam int FLUSH_BITS  = FLUSH_ZEROS_DEF;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_LEN    = 150;

   // interleaver block length per mode, in bits
   localparam int TAIL_BLOCK [16] = '{
      15 * 3, 15 * 24, 30 * 3, 30 * 24, 60 * 3, 60 * 24, 120 * 3, 120 * 24,
      120 * 3, 240 * 3, 240 * 24, 240 * 3, 480 * 3, 480 * 24, 480 * 3, 960 * 3
   };

   typedef struct packed {
      logic       bit_out;
      logic       bit_valid;
      logic       frame_done;
      logic [2:0] status;
   } tx_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = REQ_START;
   logic [7:0] req_octet_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_bit_out;
   logic       rsp_bit_valid;
   logic       rsp_frame_done;
   logic [2:0] rsp_status;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = CSR_TX_MODE;
   logic [3:0] csr_wdata = 4'd0;

   // model state: registers at their reset values
   logic [3:0] cfg_mode   = 4'd5;
   logic       cfg_lsb    = 1'b0;
   logic       cfg_eom    = 1'b1;
   logic       cfg_enable = 1'b0;
   logic       ring_store [RING_BITS];
   int         wr_ptr = 0;
   int         rd_ptr = 0;
   int         stored_bits = 0;
   int         eom_left = 0;
   int         zero_left = 0;
   phase_type  frame_ph = PH_IDLE;

   tx_result_type tx_results_due [$];
   int         fail_count = 0;
   int         cycle_count = 0;
   int         hold_token = 0;
   int         hold_token_seen = 0;
   int         hold_cycles = 0;
   logic       req_gaps_on = 1'b1;
   logic       rsp_gaps_on = 1'b1;

   modem_tx_frame_bit_serializer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_octet_value (req_octet_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bit_out     (rsp_bit_out),
      .rsp_bit_valid   (rsp_bit_valid),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: random stalls, or a counted hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_token != hold_token_seen) begin
         hold_token_seen <= hold_token;
         hold_cycles     <= HOLD_LEN - 1;
         rsp_stall       <= 1'b1;
      end else if (hold_cycles != 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= rsp_gaps_on && ($urandom_range(99) < 25);
      end
   end

   // Works out the result of one accepted request and advances the frame state.
   function automatic tx_result_type predict_tx_result(input logic [1:0] kind,
                                                       input logic [7:0] octet);
      tx_result_type res;
      logic          popped;
      int            k;
      res = '0;
      if (kind != REQ_READ && !cfg_enable) begin
         res.status = ST_DISABLED;
         return res;
      end
      case (kind)
         REQ_START: begin
            wr_ptr = 0;
            rd_ptr = 0;
            stored_bits = 0;
            eom_left = 0;
            zero_left = 0;
            frame_ph = PH_OPEN;
         end
         REQ_WRITE: begin
            if (frame_ph != PH_OPEN && frame_ph != PH_LOAD) begin
               res.status = ST_SEQUENCE;
            end else if (stored_bits + 8 > RING_BITS) begin
               res.status = ST_OVERFLOW;
            end else begin
               for (k = 0; k < 8; k++) begin
                  ring_store[wr_ptr] = cfg_lsb ? octet[k] : octet[7 - k];
                  wr_ptr = (wr_ptr + 1) % RING_BITS;
               end
               stored_bits += 8;
               frame_ph = PH_LOAD;
            end
         end
         REQ_END: begin
            if (frame_ph == PH_OPEN) begin
               frame_ph = PH_IDLE;  // empty frame: no tail at all
            end else if (frame_ph != PH_LOAD) begin
               res.status = ST_SEQUENCE;
            end else begin
               eom_left = cfg_eom ? 32 : 0;
               zero_left = FLUSH_BITS + TAIL_BLOCK[cfg_mode];
               frame_ph = PH_DRAIN;
            end
         end
         default: begin
            // ring first, then end-of-message word MSB first, then zeros
            if (stored_bits > 0) begin
               popped = ring_store[rd_ptr];
               rd_ptr = (rd_ptr + 1) % RING_BITS;
               stored_bits--;
            end else if (frame_ph == PH_DRAIN && eom_left > 0) begin
               popped = EOM_WORD[eom_left - 1];
               eom_left--;
            end else if (frame_ph == PH_DRAIN && zero_left > 0) begin
               popped = 1'b0;
               zero_left--;
            end else begin
               res.status = ST_EMPTY;
               return res;
            end
            res.bit_out = popped;
            res.bit_valid = 1'b1;
            if (frame_ph == PH_DRAIN && stored_bits == 0 && eom_left == 0 &&
                zero_left == 0) begin
               frame_ph = PH_IDLE;
               res.frame_done = 1'b1;
            end
         end
      endcase
      return res;
   endfunction

   function automatic void compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      tx_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tx_results_due.size() == 0) begin
            $error("result item with none expected");
            fail_count++;
         end else begin
            want = tx_results_due.pop_front();
            compare_field("bit_out", int'(want.bit_out), int'(rsp_bit_out));
            compare_field("bit_valid", int'(want.bit_valid), int'(rsp_bit_valid));
            compare_field("frame_done", int'(want.frame_done), int'(rsp_frame_done));
            compare_field("status", int'(want.status), int'(rsp_status));
         end
      end
   end

   // Offers one item; valid stays high on return so back-to-back items need no toggle.
   task automatic send_request(input logic [1:0] kind, input logic [7:0] octet);
      while (req_gaps_on && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_octet_value <= octet;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tx_results_due.push_back(predict_tx_result(kind, octet));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tx_results_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [3:0] value,
                            input logic last);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (last) csr_wr_en <= 1'b0;
      case (index)
         CSR_TX_MODE:   cfg_mode = value;
         CSR_LSB_FIRST: cfg_lsb = value[0];
         CSR_SEND_EOM:  cfg_eom = value[0];
         default:       cfg_enable = value[0];
      endcase
   endtask

   task automatic configure(input logic [3:0] mode, input logic lsb, input logic eom,
                            input logic enable);
      csr_write(CSR_TX_MODE, mode, 1'b0);
      csr_write(CSR_LSB_FIRST, {3'd0, lsb}, 1'b0);
      csr_write(CSR_SEND_EOM, {3'd0, eom}, 1'b0);
      csr_write(CSR_TX_ENABLE, {3'd0, enable}, 1'b1);
   endtask

   task automatic drain_frame();
      while (frame_ph == PH_DRAIN) send_request(REQ_READ, 8'($urandom_range(255)));
   endtask

   // Reset state: transmit off, then a frame at the default mode and bit order.
   task automatic test_reset_defaults();
      send_request(REQ_START, 8'h00);
      send_request(REQ_WRITE, 8'hFF);
      send_request(REQ_END, 8'h00);
      send_request(REQ_READ, 8'h00);
      wait_idle();
      csr_write(CSR_TX_ENABLE, 4'd1, 1'b1);
      send_request(REQ_START, 8'h00);
      send_request(REQ_WRITE, 8'h96);
      send_request(REQ_END, 8'h00);
      drain_frame();
   endtask

   // Requests out of order, empty frame, restarts, early reads, disable mid-frame.
   task automatic test_request_order();
      wait_idle();
      configure(4'd0, 1'b0, 1'b1, 1'b1);
      send_request(REQ_WRITE, 8'h3C);
      send_request(REQ_END, 8'h00);
      send_request(REQ_READ, 8'h00);
      send_request(REQ_START, 8'h00);
      send_request(REQ_END, 8'h00);
      send_request(REQ_END, 8'h00);
      send_request(REQ_START, 8'h00);
      send_request(REQ_READ, 8'h00);
      send_request(REQ_WRITE, 8'h00);
      send_request(REQ_WRITE, 8'hFF);
      repeat (3) send_request(REQ_READ, 8'hFF);
      send_request(REQ_START, 8'hFF);
      send_request(REQ_WRITE, 8'hC3);
      wait_idle();
      configure(4'd0, 1'b0, 1'b1, 1'b0);
      send_request(REQ_WRITE, 8'h11);
      send_request(REQ_END, 8'h00);
      send_request(REQ_START, 8'h00);
      send_request(REQ_READ, 8'h00);
      wait_idle();
      configure(4'd0, 1'b0, 1'b1, 1'b1);
      send_request(REQ_END, 8'h00);
      send_request(REQ_WRITE, 8'h77);
      send_request(REQ_END, 8'h00);
      repeat (5) send_request(REQ_READ, 8'h00);
      send_request(REQ_START, 8'h00);
      send_request(REQ_WRITE, 8'hA5);
      send_request(REQ_END, 8'h00);
      drain_frame();
   endtask

   // Both bit orders, with and without the end-of-message word.
   task automatic test_bit_order();
      int v;
      for (v = 0; v < 4; v++) begin
         wait_idle();
         configure(4'd0, v[0], v[1], 1'b1);
         send_request(REQ_START, 8'h00);
         send_request(REQ_WRITE, 8'h01);
         send_request(REQ_WRITE, 8'h80);
         send_request(REQ_WRITE, 8'h5A);
         send_request(REQ_END, 8'h00);
         drain_frame();
      end
   endtask

   // One full frame per mode so every interleaver block length is drained.
   task automatic test_mode_tails();
      int m;
      for (m = 0; m < 16; m++) begin
         wait_idle();
         configure(4'(m), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
         send_request(REQ_START, 8'($urandom_range(255)));
         send_request(REQ_WRITE, 8'($urandom_range(255)));
         send_request(REQ_END, 8'($urandom_range(255)));
         drain_frame();
      end
   endtask

   // Fill the ring, overflow, free a little, wrap the write pointer, overflow again.
   task automatic test_ring_overflow();
      wait_idle();
      configure(4'd0, 1'($urandom_range(1)), 1'b1, 1'b1);
      send_request(REQ_START, 8'h00);
      repeat (RING_BITS / 8) send_request(REQ_WRITE, 8'($urandom_range(255)));
      send_request(REQ_WRITE, 8'($urandom_range(255)));
      repeat (100) send_request(REQ_READ, 8'($urandom_range(255)));
      repeat (12) send_request(REQ_WRITE, 8'($urandom_range(255)));
      send_request(REQ_WRITE, 8'($urandom_range(255)));
      send_request(REQ_END, 8'h00);
      drain_frame();
   endtask

   // Receiver holds off for a long stretch while items keep coming, no idling.
   task automatic test_output_hold();
      wait_idle();
      configure(4'd0, 1'b1, 1'b0, 1'b1);
      req_gaps_on = 1'b0;
      rsp_gaps_on <= 1'b0;
      send_request(REQ_START, 8'h00);
      hold_token <= hold_token + 1;
      repeat (40) send_request(REQ_WRITE, 8'($urandom_range(255)));
      repeat (40) send_request(REQ_READ, 8'($urandom_range(255)));
      send_request(REQ_END, 8'h00);
      drain_frame();
      req_gaps_on = 1'b1;
      rsp_gaps_on <= 1'b1;
   endtask

   // Mostly well-formed frames driven by the model's phase; some noise on top.
   function automatic logic [1:0] pick_request();
      int roll;
      if ($urandom_range(9) == 0) return 2'($urandom_range(3));
      roll = $urandom_range(9);
      case (frame_ph)
         PH_IDLE: return REQ_START;
         PH_OPEN: return (roll < 2) ? REQ_END : REQ_WRITE;
         PH_LOAD: return (roll < 4) ? REQ_WRITE : (roll < 9) ? REQ_READ : REQ_END;
         default: return REQ_READ;
      endcase
   endfunction

   task automatic test_random_traffic();
      int         counted;
      int         phase_no;
      logic [1:0] kind;
      logic [3:0] mode;
      counted = 0;
      phase_no = 0;
      while (counted < 800) begin
         wait_idle();
         // short tails most of the time so frames finish within a phase
         mode = ($urandom_range(3) != 0) ? 4'(2 * $urandom_range(4)) : 4'($urandom_range(15));
         configure(mode, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   $urandom_range(9) != 0);
         req_gaps_on = (phase_no != 2);
         rsp_gaps_on <= (phase_no != 2);
         repeat ($urandom_range(60, 300)) begin
            kind = pick_request();
            send_request(kind, 8'($urandom_range(255)));
            if (kind == REQ_READ || cfg_enable) counted++;
         end
         phase_no++;
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on <= 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_request_order();
      test_bit_order();
      test_mode_tails();
      test_ring_overflow();
      test_output_hold();
      test_random_traffic();
      wait_idle();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
